/* rtl/core/cau_pkg.sv */
`default_nettype none

package cau_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned PROD_W  = 2 * FIELD_W;
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_CONJ  = 3'd4,
        OP_NEG   = 3'd5,
        OP_SQMAG = 3'd6,
        OP_MAG   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

    typedef struct packed {
        t_op                        action;
        logic signed [FIELD_W-1:0]  a_re;
        logic signed [FIELD_W-1:0]  a_im;
        logic signed [FIELD_W-1:0]  b_re;
        logic signed [FIELD_W-1:0]  b_im;
    } t_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  res_re;
        logic signed [FIELD_W-1:0]  res_im;
        t_status                    status;
    } t_out;

    typedef struct packed {
        t_op                        action;
        logic signed [FIELD_W-1:0]  a_re;
        logic signed [FIELD_W-1:0]  a_im;
        logic signed [FIELD_W-1:0]  b_re;
        logic signed [FIELD_W-1:0]  b_im;
        logic signed [PROD_W-1:0]   p_rr;
        logic signed [PROD_W-1:0]   p_ii;
        logic signed [PROD_W-1:0]   p_ri;
        logic signed [PROD_W-1:0]   p_ir;
        logic signed [PROD_W-1:0]   p_bb_r;
        logic signed [PROD_W-1:0]   p_bb_i;
    } t_qitem;

endpackage

`default_nettype wire

/* rtl/core/cau_front.sv */
`default_nettype none

module cau_front import cau_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_in     i_in,
    output logic    o_q_valid,
    input  logic    i_q_ready,
    output t_qitem  o_q_item
);

    logic                       w_square;
    logic signed [FIELD_W-1:0]  w_mr;
    logic signed [FIELD_W-1:0]  w_mi;
    t_qitem                     n_item;
    t_qitem                     r_item;
    logic                       r_vld;

    assign o_in_ready = !r_vld || i_q_ready;
    assign o_q_valid  = r_vld;
    assign o_q_item   = r_item;

    // squared magnitude and magnitude reuse the cross products with b taken as a
    assign w_square = (i_in.action == OP_SQMAG) || (i_in.action == OP_MAG);
    assign w_mr     = w_square ? i_in.a_re : i_in.b_re;
    assign w_mi     = w_square ? i_in.a_im : i_in.b_im;

    always_comb begin
        n_item.action = i_in.action;
        n_item.a_re   = i_in.a_re;
        n_item.a_im   = i_in.a_im;
        n_item.b_re   = i_in.b_re;
        n_item.b_im   = i_in.b_im;
        n_item.p_rr   = i_in.a_re * w_mr;
        n_item.p_ii   = i_in.a_im * w_mi;
        n_item.p_ri   = i_in.a_re * w_mi;
        n_item.p_ir   = i_in.a_im * w_mr;
        n_item.p_bb_r = i_in.b_re * i_in.b_re;
        n_item.p_bb_i = i_in.b_im * i_in.b_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cau_queue.sv */
`default_nettype none

module cau_queue import cau_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr_valid,
    output logic    o_wr_ready,
    input  t_qitem  i_wr_item,
    output logic    o_rd_valid,
    input  logic    i_rd_ready,
    output t_qitem  o_rd_item
);

    t_qitem                 r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]     r_wr_ptr;
    logic [Q_PTR_W-1:0]     r_rd_ptr;
    logic [Q_CNT_W-1:0]     r_cnt;
    logic                   w_push;
    logic                   w_pop;

    assign o_wr_ready = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cau_back.sv */
`default_nettype none

module cau_back import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    output logic    o_q_ready,
    input  t_qitem  i_q_item,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out
);

    localparam int QW   = FIELD_W + 2;
    localparam int RT_W = PROD_W / 2;
    localparam int NSTG = QW;
    localparam int SW   = PROD_W + 3;
    localparam int EW   = (DATA_WIDTH > FIELD_W) ? FIELD_W : DATA_WIDTH;
    localparam logic signed [SW-1:0] ONE_S  = SW'(1);
    localparam logic signed [SW-1:0] SAT_HI = (ONE_S <<< (EW - 1)) - ONE_S;
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [1:0] {
        KD_PLAIN,
        KD_DIV,
        KD_MAG
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic                   dz;
        logic signed [SW-1:0]   re;
        logic signed [SW-1:0]   im;
        logic [PROD_W-1:0]      den;
        logic [PROD_W-1:0]      rem_re;
        logic [PROD_W-1:0]      rem_im;
        logic [QW-1:0]          num_re;
        logic [QW-1:0]          num_im;
        logic [QW-1:0]          quo_re;
        logic [QW-1:0]          quo_im;
        logic                   neg_re;
        logic                   neg_im;
        logic                   ovf_re;
        logic                   ovf_im;
        logic [RT_W+1:0]        sq_rem;
        logic [RT_W-1:0]        sq_root;
        logic [PROD_W-1:0]      sq_src;
    } t_stage;

    function automatic logic [PROD_W+2*QW-1:0] div_step(
        input logic [PROD_W-1:0] rem,
        input logic [QW-1:0]     num,
        input logic [QW-1:0]     quo,
        input logic [PROD_W-1:0] den
    );
        logic [PROD_W:0] t;
        logic            ge;
        t  = {rem, num[QW-1]};
        ge = (t >= {1'b0, den});
        if (ge) begin
            t = t - {1'b0, den};
        end
        return {t[PROD_W-1:0], num << 1, quo[QW-2:0], ge};
    endfunction

    function automatic logic [RT_W+2+RT_W+PROD_W-1:0] sqrt_step(
        input logic [RT_W+1:0]   rem,
        input logic [RT_W-1:0]   root,
        input logic [PROD_W-1:0] src
    );
        logic [RT_W+3:0] cur;
        logic [RT_W+3:0] trial;
        logic            ge;
        cur   = {rem, src[PROD_W-1 -: 2]};
        trial = {2'b00, root, 2'b01};
        ge    = (cur >= trial);
        if (ge) begin
            cur = cur - trial;
        end
        return {cur[RT_W+1:0], root[RT_W-2:0], ge, src << 2};
    endfunction

    t_stage                 r_stg [0:NSTG];
    t_stage                 n_stg [1:NSTG];
    t_stage                 n_first;
    logic [NSTG:0]          r_vld;
    logic                   w_en;
    t_out                   r_out;
    t_out                   n_out;
    logic                   r_out_vld;

    logic signed [SW-1:0]   w_sq;
    logic signed [SW-1:0]   w_nr;
    logic signed [SW-1:0]   w_ni;
    logic signed [SW-1:0]   w_den;
    logic [PROD_W-1:0]      w_mag_re;
    logic [PROD_W-1:0]      w_mag_im;
    logic [PROD_W-1:0]      w_sh_re;
    logic [PROD_W-1:0]      w_sh_im;
    logic [PROD_W-1:0]      w_hi_re;
    logic [PROD_W-1:0]      w_hi_im;

    logic signed [SW-1:0]   w_vr;
    logic signed [SW-1:0]   w_vi;
    logic signed [SW-1:0]   w_qr;
    logic signed [SW-1:0]   w_qi;
    logic signed [SW-1:0]   w_sr;
    logic signed [SW-1:0]   w_si;
    logic                   w_sat;

    assign w_en        = !r_out_vld || i_out_ready;
    assign o_q_ready   = w_en;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    always_comb begin
        w_sq     = SW'(i_q_item.p_rr) + SW'(i_q_item.p_ii);
        w_nr     = SW'(i_q_item.p_rr) + SW'(i_q_item.p_ii);
        w_ni     = SW'(i_q_item.p_ir) - SW'(i_q_item.p_ri);
        w_den    = SW'(i_q_item.p_bb_r) + SW'(i_q_item.p_bb_i);
        w_mag_re = w_nr[SW-1] ? PROD_W'(-w_nr) : PROD_W'(w_nr);
        w_mag_im = w_ni[SW-1] ? PROD_W'(-w_ni) : PROD_W'(w_ni);
        w_sh_re  = w_mag_re << FRAC_BITS;
        w_sh_im  = w_mag_im << FRAC_BITS;
        w_hi_re  = w_mag_re >> (QW - FRAC_BITS);
        w_hi_im  = w_mag_im >> (QW - FRAC_BITS);

        n_first        = '0;
        n_first.kind   = KD_PLAIN;
        n_first.den    = PROD_W'(w_den);
        n_first.rem_re = w_hi_re;
        n_first.rem_im = w_hi_im;
        n_first.num_re = w_sh_re[QW-1:0];
        n_first.num_im = w_sh_im[QW-1:0];
        n_first.neg_re = w_nr[SW-1];
        n_first.neg_im = w_ni[SW-1];
        n_first.ovf_re = (w_hi_re >= PROD_W'(w_den));
        n_first.ovf_im = (w_hi_im >= PROD_W'(w_den));
        n_first.sq_src = PROD_W'(w_sq);

        unique case (i_q_item.action)
            OP_ADD: begin
                n_first.re = SW'(i_q_item.a_re) + SW'(i_q_item.b_re);
                n_first.im = SW'(i_q_item.a_im) + SW'(i_q_item.b_im);
            end
            OP_SUB: begin
                n_first.re = SW'(i_q_item.a_re) - SW'(i_q_item.b_re);
                n_first.im = SW'(i_q_item.a_im) - SW'(i_q_item.b_im);
            end
            OP_MUL: begin
                n_first.re = (SW'(i_q_item.p_rr) - SW'(i_q_item.p_ii)) >>> FRAC_BITS;
                n_first.im = (SW'(i_q_item.p_ri) + SW'(i_q_item.p_ir)) >>> FRAC_BITS;
            end
            OP_DIV: begin
                if (w_den == '0) begin
                    n_first.dz = 1'b1;
                end else begin
                    n_first.kind = KD_DIV;
                end
            end
            OP_CONJ: begin
                n_first.re = SW'(i_q_item.a_re);
                n_first.im = -SW'(i_q_item.a_im);
            end
            OP_NEG: begin
                n_first.re = -SW'(i_q_item.a_re);
                n_first.im = -SW'(i_q_item.a_im);
            end
            OP_SQMAG: begin
                n_first.re = w_sq >>> FRAC_BITS;
            end
            OP_MAG: begin
                n_first.kind = KD_MAG;
            end
            default: begin
                n_first.kind = KD_PLAIN;
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            n_stg[k+1] = r_stg[k];
            {n_stg[k+1].rem_re, n_stg[k+1].num_re, n_stg[k+1].quo_re} =
                div_step(r_stg[k].rem_re, r_stg[k].num_re, r_stg[k].quo_re, r_stg[k].den);
            {n_stg[k+1].rem_im, n_stg[k+1].num_im, n_stg[k+1].quo_im} =
                div_step(r_stg[k].rem_im, r_stg[k].num_im, r_stg[k].quo_im, r_stg[k].den);
            if (k < RT_W) begin
                {n_stg[k+1].sq_rem, n_stg[k+1].sq_root, n_stg[k+1].sq_src} =
                    sqrt_step(r_stg[k].sq_rem, r_stg[k].sq_root, r_stg[k].sq_src);
            end
        end
    end

    always_comb begin
        w_qr = $signed(SW'(r_stg[NSTG].quo_re));
        w_qi = $signed(SW'(r_stg[NSTG].quo_im));
        unique case (r_stg[NSTG].kind)
            KD_DIV: begin
                if (r_stg[NSTG].ovf_re) begin
                    w_vr = r_stg[NSTG].neg_re ? SAT_LO - ONE_S : SAT_HI + ONE_S;
                end else begin
                    w_vr = r_stg[NSTG].neg_re ? -w_qr : w_qr;
                end
                if (r_stg[NSTG].ovf_im) begin
                    w_vi = r_stg[NSTG].neg_im ? SAT_LO - ONE_S : SAT_HI + ONE_S;
                end else begin
                    w_vi = r_stg[NSTG].neg_im ? -w_qi : w_qi;
                end
            end
            KD_MAG: begin
                w_vr = $signed(SW'(r_stg[NSTG].sq_root));
                w_vi = '0;
            end
            default: begin
                w_vr = r_stg[NSTG].re;
                w_vi = r_stg[NSTG].im;
            end
        endcase

        w_sat = 1'b0;
        w_sr  = w_vr;
        w_si  = w_vi;
        if (w_vr > SAT_HI) begin
            w_sr  = SAT_HI;
            w_sat = 1'b1;
        end else if (w_vr < SAT_LO) begin
            w_sr  = SAT_LO;
            w_sat = 1'b1;
        end
        if (w_vi > SAT_HI) begin
            w_si  = SAT_HI;
            w_sat = 1'b1;
        end else if (w_vi < SAT_LO) begin
            w_si  = SAT_LO;
            w_sat = 1'b1;
        end

        n_out.res_re = w_sr[FIELD_W-1:0];
        n_out.res_im = w_si[FIELD_W-1:0];
        if (r_stg[NSTG].dz) begin
            n_out.status = ST_DIV_ZERO;
        end else if (w_sat) begin
            n_out.status = ST_SAT;
        end else begin
            n_out.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[NSTG-1:0], i_q_valid};
            r_out_vld <= r_vld[NSTG];
        end
        if (w_en) begin
            r_stg[0] <= n_first;
            for (int k = 1; k <= NSTG; k++) begin
                r_stg[k] <= n_stg[k];
            end
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/complex_arithmetic_unit.sv */
`default_nettype none

// Complex-number ALU on signed fixed point (FRAC_BITS fraction bits): add, subtract,
// multiply, divide, conjugate, negate, squared magnitude and magnitude, one result
// with status per item. Takes one item per clock and delivers one result per clock
// while the output is not stalled. An item passes the operand-product register,
// the queue, the register that combines products, the pipelined restoring divider
// (one quotient bit per stage, the square root shares these stages) and the
// saturation register; a four-entry queue lets input flow while the output stalls.

module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_in     i_in,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out
);

    logic   w_fq_valid;
    logic   w_fq_ready;
    t_qitem w_fq_item;
    logic   w_qb_valid;
    logic   w_qb_ready;
    t_qitem w_qb_item;

    cau_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_q_valid  (w_fq_valid),
        .i_q_ready  (w_fq_ready),
        .o_q_item   (w_fq_item)
    );

    cau_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fq_valid),
        .o_wr_ready (w_fq_ready),
        .i_wr_item  (w_fq_item),
        .o_rd_valid (w_qb_valid),
        .i_rd_ready (w_qb_ready),
        .o_rd_item  (w_qb_item)
    );

    cau_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_qb_valid),
        .o_q_ready   (w_qb_ready),
        .i_q_item    (w_qb_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none

module tb_top import cau_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DATA_WIDTH    = 32;
    localparam int  FRAC_BITS     = 16;
    localparam int  LATENCY       = 38;
    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  RANDOM_ITEMS  = 630;
    localparam logic signed [31:0] MAX_Q = 32'sh7fffffff;
    localparam logic signed [31:0] MIN_Q = 32'sh80000000;
    localparam logic signed [31:0] ONE_Q = 32'sh00010000;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_ready;
    t_in    i_in;
    logic   o_out_valid;
    logic   i_out_ready;
    t_out   o_out;

    t_out   expected_results[$];
    int     mismatch_count;
    int     cycle_count;
    bit     idle_enable;

    complex_arithmetic_unit #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] clamp_q(input logic signed [127:0] v,
                                                   inout bit clipped);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            clipped = 1'b1;
            return hi[31:0];
        end
        if (v < lo) begin
            clipped = 1'b1;
            return lo[31:0];
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] probe;
        root = 64'd0;
        probe = 64'd1 << 62;
        while (probe > n) probe = probe >> 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [127:0] trunc_div(input logic signed [127:0] num,
                                                      input logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] quo;
        mag = (num < 0) ? -num : num;
        if (mag / den >= (128'sd1 <<< 32))
            quo = 128'sd1 <<< (32 + FRAC_BITS);
        else
            quo = (mag <<< FRAC_BITS) / den;
        return (num < 0) ? -quo : quo;
    endfunction

    function automatic t_out complex_result(input t_in x);
        logic signed [127:0] ar, ai, br, bi, re, im, den, sq;
        bit     clipped;
        t_out   r;
        ar = x.a_re;
        ai = x.a_im;
        br = x.b_re;
        bi = x.b_im;
        re = 0;
        im = 0;
        clipped = 1'b0;
        r.status = ST_OK;
        case (x.action)
            OP_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            OP_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            OP_MUL: begin
                re = (ar * br - ai * bi) >>> FRAC_BITS;
                im = (ar * bi + ai * br) >>> FRAC_BITS;
            end
            OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.status = ST_DIV_ZERO;
                end else begin
                    re = trunc_div(ar * br + ai * bi, den);
                    im = trunc_div(ai * br - ar * bi, den);
                end
            end
            OP_CONJ: begin
                re = ar;
                im = -ai;
            end
            OP_NEG: begin
                re = -ar;
                im = -ai;
            end
            OP_SQMAG: begin
                sq = (ar * ar + ai * ai) >>> FRAC_BITS;
                if (sq > (128'sd1 <<< 40)) sq = 128'sd1 <<< 40;
                re = sq;
            end
            default: begin
                sq = ar * ar + ai * ai;
                re = int_sqrt(sq[63:0]);
            end
        endcase
        r.res_re = clamp_q(re, clipped);
        r.res_im = clamp_q(im, clipped);
        if (clipped && r.status == ST_OK) r.status = ST_SAT;
        return r;
    endfunction

    task automatic idle_cycles();
        int n;
        n = $urandom_range(13, 1);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_item(input t_in x);
        if (idle_enable && $urandom_range(9, 0) == 0) idle_cycles();
        i_in_valid <= 1'b1;
        i_in <= x;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        expected_results.push_back(complex_result(x));
    endtask

    function automatic t_in make_item(input t_op op, input logic [31:0] ar,
                                      input logic [31:0] ai, input logic [31:0] br,
                                      input logic [31:0] bi);
        t_in x;
        x.action = op;
        x.a_re = ar;
        x.a_im = ai;
        x.b_re = br;
        x.b_im = bi;
        return x;
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(5, 0))
            0: return $urandom_range(1, 0) ? MAX_Q : MIN_Q;
            1: return 32'($signed($urandom_range(8, 0)) - 4) * ONE_Q;
            2: return 32'($signed($urandom_range(2000, 0)) - 1000);
            3: return 32'($signed($urandom_range(1 << 24, 0)) - (1 << 23));
            4: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: re=%h im=%h st=%0d",
                             o_out.res_re, o_out.res_im, o_out.status);
            end else begin
                want = expected_results.pop_front();
                if (o_out.res_re !== want.res_re || o_out.res_im !== want.res_im ||
                    o_out.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp re=%h im=%h st=%0d got re=%h im=%h st=%0d",
                                 want.res_re, want.res_im, want.status,
                                 o_out.res_re, o_out.res_im, o_out.status);
                end
            end
        end
    end

    initial begin
        int n;
        i_out_ready = 1'b1;
        @(posedge i_clk);
        forever begin
            if (idle_enable && $urandom_range(7, 0) == 0) begin
                n = $urandom_range(13, 1);
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            n = $urandom_range(30, 1);
            repeat (n) @(posedge i_clk);
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic test_reset();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        idle_enable = 1'b1;
        mismatch_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_operations();
        send_item(make_item(OP_ADD, MAX_Q, MIN_Q, ONE_Q, -ONE_Q));
        send_item(make_item(OP_ADD, MIN_Q, MAX_Q, MIN_Q, MAX_Q));
        send_item(make_item(OP_SUB, MIN_Q, MAX_Q, ONE_Q, -ONE_Q));
        send_item(make_item(OP_SUB, 32'sd5, -32'sd7, 32'sd3, 32'sd9));
        send_item(make_item(OP_MUL, ONE_Q * 3, -ONE_Q, -ONE_Q * 2, ONE_Q * 5));
        send_item(make_item(OP_MUL, -32'sd3, 32'sd1, 32'sd1, 32'sd1));
        send_item(make_item(OP_MUL, MAX_Q, MIN_Q, MAX_Q, MIN_Q));
        send_item(make_item(OP_MUL, MIN_Q, MIN_Q, MIN_Q, MIN_Q));
        send_item(make_item(OP_DIV, ONE_Q * 7, -ONE_Q * 3, ONE_Q * 2, ONE_Q));
        send_item(make_item(OP_DIV, -32'sd1, 32'sd0, ONE_Q * 3, 32'sd0));
        send_item(make_item(OP_DIV, ONE_Q, ONE_Q, 32'sd0, 32'sd0));
        send_item(make_item(OP_DIV, MAX_Q, MIN_Q, 32'sd1, 32'sd0));
        send_item(make_item(OP_DIV, MIN_Q, MIN_Q, MIN_Q, MAX_Q));
        send_item(make_item(OP_CONJ, MAX_Q, MIN_Q, 32'd0, 32'd0));
        send_item(make_item(OP_CONJ, MIN_Q, MAX_Q, $urandom, $urandom));
        send_item(make_item(OP_NEG, MIN_Q, 32'sd1, 32'd0, 32'd0));
        send_item(make_item(OP_NEG, MAX_Q, -32'sd1, 32'd0, 32'd0));
        send_item(make_item(OP_SQMAG, ONE_Q * 3, ONE_Q * 4, 32'd0, 32'd0));
        send_item(make_item(OP_SQMAG, MIN_Q, MIN_Q, 32'd0, 32'd0));
        send_item(make_item(OP_SQMAG, -32'sd300, 32'sd5, 32'd0, 32'd0));
        send_item(make_item(OP_MAG, ONE_Q * 3, -ONE_Q * 4, 32'd0, 32'd0));
        send_item(make_item(OP_MAG, MIN_Q, MIN_Q, 32'd0, 32'd0));
        send_item(make_item(OP_MAG, MAX_Q, 32'sd0, 32'd0, 32'd0));
    endtask

    task automatic test_drained_pause();
        i_in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic test_random(input int count);
        t_in x;
        for (int k = 0; k < count; k++) begin
            x.action = t_op'($urandom_range(7, 0));
            x.a_re = random_operand();
            x.a_im = random_operand();
            x.b_re = random_operand();
            x.b_im = random_operand();
            if (x.action == OP_DIV && $urandom_range(9, 0) == 0) begin
                x.b_re = '0;
                x.b_im = '0;
            end
            send_item(x);
        end
    endtask

    task automatic test_drain();
        i_in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    initial begin
        test_reset();
        test_operations();
        test_drained_pause();
        test_random(RANDOM_ITEMS - 60);
        idle_enable = 1'b0;
        test_random(60);
        test_drain();
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
